/* rtl/g2l_pkg.sv */
// Shared constants and types for the geodetic-to-local rotation matrix block.
package g2l_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  localparam int OUT_W  = 16;   // width of every matrix entry on the result channel
  localparam int TURN_W = 32;   // angle left-aligned to a full turn
  localparam int Q_FRAC = 30;   // fraction bits of a quarter turn
  localparam int Q_W    = 31;   // Q30 values up to and including 1.0

  typedef logic [Q_W-1:0] q30_t;
  typedef logic signed [OUT_W-1:0] entry_t;

  localparam q30_t Q30_ONE = q30_t'(32'h4000_0000);

  // Odd polynomial for sin(pi/2 * t), Horner order from the top term down.
  localparam q30_t POLY_C9 = q30_t'(32'd172272);
  localparam q30_t POLY_C7 = q30_t'(32'd5026995);
  localparam q30_t POLY_C5 = q30_t'(32'd85569306);
  localparam q30_t POLY_C3 = q30_t'(32'd693598669);
  localparam q30_t POLY_C1 = q30_t'(32'd1686629713);

  localparam int POLY_STEPS = 4;
  localparam q30_t POLY_COEF [POLY_STEPS] = '{POLY_C7, POLY_C5, POLY_C3, POLY_C1};

  // Pipeline depth of each section.
  localparam int SINE_STAGES   = 7;
  localparam int SINCOS_STAGES = SINE_STAGES + 2;
  localparam int MUL_STAGES    = 2;
  localparam int PIPE_STAGES   = SINCOS_STAGES + MUL_STAGES;

endpackage

/* rtl/g2l_if.sv */
// Valid/ready channel interfaces for the angle input and the matrix result.
interface g2l_in_if #(
  parameter int ANGLE_BITS = g2l_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] latitude_angle;
  logic [ANGLE_BITS-1:0] longitude_angle;

  modport source (output valid, output latitude_angle, output longitude_angle, input ready);
  modport sink   (input valid, input latitude_angle, input longitude_angle, output ready);
endinterface

interface g2l_out_if;
  logic            valid;
  logic            ready;
  g2l_pkg::entry_t east_x;
  g2l_pkg::entry_t east_y;
  g2l_pkg::entry_t north_x;
  g2l_pkg::entry_t north_y;
  g2l_pkg::entry_t north_z;
  g2l_pkg::entry_t up_x;
  g2l_pkg::entry_t up_y;
  g2l_pkg::entry_t up_z;

  modport source (output valid, input ready,
                  output east_x, output east_y,
                  output north_x, output north_y, output north_z,
                  output up_x, output up_y, output up_z);
  modport sink   (input valid, output ready,
                  input east_x, input east_y,
                  input north_x, input north_y, input north_z,
                  input up_x, input up_y, input up_z);
endinterface

/* rtl/g2l_pipe_ctrl.sv */
// Valid bits and per-stage load enables for the elastic pipeline.
module g2l_pipe_ctrl #(
  parameter int STAGES = g2l_pkg::PIPE_STAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAGES-1:0] load
);

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic [STAGES-1:0] prev_valid;
  logic [STAGES:0]   stage_rdy;

  assign stage_rdy[STAGES] = out_ready;
  assign prev_valid[0]     = in_valid;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    if (k > 0) begin : g_prev
      assign prev_valid[k] = valid_r[k-1];
    end
    // A stage takes a new word when it is empty or its word moves on.
    assign stage_rdy[k] = !valid_r[k] || stage_rdy[k+1];
    assign load[k]      = stage_rdy[k] && prev_valid[k];
    assign valid_nxt[k] = stage_rdy[k] ? prev_valid[k] : valid_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = stage_rdy[0];
  assign out_valid = valid_r[STAGES-1];

endmodule

/* rtl/g2l_sine_poly.sv */
// Pipelined quarter-wave sine polynomial, at most one multiply per stage.
module g2l_sine_poly #(
  parameter int COEF_FRAC_BITS = g2l_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [g2l_pkg::SINE_STAGES-1:0]    load,
  input  g2l_pkg::q30_t                      t,
  output logic [COEF_FRAC_BITS:0]            mag
);

  localparam int QW     = g2l_pkg::Q_W;
  localparam int QF     = g2l_pkg::Q_FRAC;
  localparam int TW     = g2l_pkg::TURN_W;
  localparam int NSTEP  = g2l_pkg::POLY_STEPS;
  localparam int RND_SH = QF - COEF_FRAC_BITS;
  localparam logic [TW-1:0] RND_HALF = (TW'(1) << RND_SH) >> 1;
  localparam logic [TW-1:0] LIM      = TW'(1) << COEF_FRAC_BITS;

  // Q30 product truncated toward zero.
  function automatic g2l_pkg::q30_t qmul(input g2l_pkg::q30_t a, input g2l_pkg::q30_t b);
    logic [2*QW-1:0] prod;
    prod = {{QW{1'b0}}, a} * {{QW{1'b0}}, b};
    return prod[QF+QW-1:QF];
  endfunction

  g2l_pkg::q30_t t_r  [NSTEP+1];
  g2l_pkg::q30_t t2_r [NSTEP];
  g2l_pkg::q30_t p_r  [1:NSTEP];
  g2l_pkg::q30_t s_r;
  logic [COEF_FRAC_BITS:0] mag_r;

  logic [TW-1:0] s_sum;
  logic [TW-1:0] s_shift;
  logic [TW-1:0] s_sat;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      t_r[0]  <= t;
      t2_r[0] <= qmul(t, t);
    end
  end

  // Horner steps: p = C - p * t^2
  for (genvar k = 1; k <= NSTEP; k++) begin : g_horner
    g2l_pkg::q30_t p_prev;
    if (k == 1) begin : g_first
      assign p_prev = g2l_pkg::POLY_C9;
    end else begin : g_next
      assign p_prev = p_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (load[k]) begin
        p_r[k] <= g2l_pkg::POLY_COEF[k-1] - qmul(p_prev, t2_r[k-1]);
        t_r[k] <= t_r[k-1];
      end
    end

    // The last step no longer needs t^2.
    if (k < NSTEP) begin : g_t2
      always_ff @(posedge clk) begin
        if (load[k]) begin
          t2_r[k] <= t2_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[NSTEP+1]) begin
      s_r <= qmul(p_r[NSTEP], t_r[NSTEP]);
    end
  end

  // Round half up to the coefficient grid, clamp at one.
  always_comb begin
    s_sum   = TW'(s_r) + RND_HALF;
    s_shift = s_sum >> RND_SH;
    s_sat   = (s_shift > LIM) ? LIM : s_shift;
  end

  always_ff @(posedge clk) begin
    if (load[NSTEP+2]) begin
      mag_r <= s_sat[COEF_FRAC_BITS:0];
    end
  end

  assign mag = mag_r;

endmodule

/* rtl/g2l_sincos.sv */
// Sine and cosine of one binary angle as magnitude and sign.
module g2l_sincos #(
  parameter int ANGLE_BITS     = g2l_pkg::ANGLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = g2l_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [g2l_pkg::SINCOS_STAGES-1:0]  load,
  input  logic [ANGLE_BITS-1:0]              angle,
  output logic [COEF_FRAC_BITS:0]            sin_mag,
  output logic                               sin_neg,
  output logic [COEF_FRAC_BITS:0]            cos_mag,
  output logic                               cos_neg
);

  localparam int TW = g2l_pkg::TURN_W;
  localparam int QF = g2l_pkg::Q_FRAC;
  localparam int NS = g2l_pkg::SINE_STAGES;

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_t;

  logic [TW-1:0] turn;
  g2l_pkg::q30_t x_r;
  g2l_pkg::q30_t xc_r;
  quad_t         quad_r [NS+1];

  logic [COEF_FRAC_BITS:0] sx_mag;
  logic [COEF_FRAC_BITS:0] cx_mag;

  logic [COEF_FRAC_BITS:0] sin_mag_r, sin_mag_nxt;
  logic [COEF_FRAC_BITS:0] cos_mag_r, cos_mag_nxt;
  logic                    sin_neg_r, sin_neg_nxt;
  logic                    cos_neg_r, cos_neg_nxt;
  logic                    sin_sgn, cos_sgn;

  assign turn = TW'(angle) << (TW - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      quad_r[0] <= quad_t'(turn[TW-1 -: 2]);
      x_r       <= {1'b0, turn[QF-1:0]};
      xc_r      <= g2l_pkg::Q30_ONE - {1'b0, turn[QF-1:0]};
    end
  end

  g2l_sine_poly #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_poly_sin (
    .clk  (clk),
    .load (load[NS:1]),
    .t    (x_r),
    .mag  (sx_mag)
  );

  g2l_sine_poly #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_poly_cos (
    .clk  (clk),
    .load (load[NS:1]),
    .t    (xc_r),
    .mag  (cx_mag)
  );

  // Carry the quadrant alongside the polynomial.
  for (genvar k = 1; k <= NS; k++) begin : g_quad
    always_ff @(posedge clk) begin
      if (load[k]) begin
        quad_r[k] <= quad_r[k-1];
      end
    end
  end

  always_comb begin
    case (quad_r[NS])
      QUAD_I: begin
        sin_mag_nxt = sx_mag; sin_sgn = 1'b0;
        cos_mag_nxt = cx_mag; cos_sgn = 1'b0;
      end
      QUAD_II: begin
        sin_mag_nxt = cx_mag; sin_sgn = 1'b0;
        cos_mag_nxt = sx_mag; cos_sgn = 1'b1;
      end
      QUAD_III: begin
        sin_mag_nxt = sx_mag; sin_sgn = 1'b1;
        cos_mag_nxt = cx_mag; cos_sgn = 1'b1;
      end
      QUAD_IV: begin
        sin_mag_nxt = cx_mag; sin_sgn = 1'b1;
        cos_mag_nxt = sx_mag; cos_sgn = 1'b0;
      end
      default: begin
        sin_mag_nxt = sx_mag; sin_sgn = 1'b0;
        cos_mag_nxt = cx_mag; cos_sgn = 1'b0;
      end
    endcase
    // A zero magnitude never counts as negative.
    sin_neg_nxt = sin_sgn && (sin_mag_nxt != '0);
    cos_neg_nxt = cos_sgn && (cos_mag_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (load[NS+1]) begin
      sin_mag_r <= sin_mag_nxt;
      sin_neg_r <= sin_neg_nxt;
      cos_mag_r <= cos_mag_nxt;
      cos_neg_r <= cos_neg_nxt;
    end
  end

  assign sin_mag = sin_mag_r;
  assign sin_neg = sin_neg_r;
  assign cos_mag = cos_mag_r;
  assign cos_neg = cos_neg_r;

endmodule

/* rtl/g2l_rot_mul.sv */
// Cross products of the angle terms and assembly of the eight matrix entries.
module g2l_rot_mul #(
  parameter int COEF_FRAC_BITS = g2l_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic [g2l_pkg::MUL_STAGES-1:0]  load,
  input  logic [COEF_FRAC_BITS:0]         sp_mag,
  input  logic                            sp_neg,
  input  logic [COEF_FRAC_BITS:0]         cp_mag,
  input  logic                            cp_neg,
  input  logic [COEF_FRAC_BITS:0]         sl_mag,
  input  logic                            sl_neg,
  input  logic [COEF_FRAC_BITS:0]         cl_mag,
  input  logic                            cl_neg,
  output g2l_pkg::entry_t                 east_x,
  output g2l_pkg::entry_t                 east_y,
  output g2l_pkg::entry_t                 north_x,
  output g2l_pkg::entry_t                 north_y,
  output g2l_pkg::entry_t                 north_z,
  output g2l_pkg::entry_t                 up_x,
  output g2l_pkg::entry_t                 up_y,
  output g2l_pkg::entry_t                 up_z
);

  localparam int F  = COEF_FRAC_BITS;
  localparam int MW = F + 1;
  localparam int CW = F + 2;
  localparam int PW = 2 * F + 2;
  localparam int OW = g2l_pkg::OUT_W;
  localparam logic [PW-1:0] PR_HALF = PW'(1) << (F - 1);

  function automatic logic [CW-1:0] to_signed(input logic neg, input logic [MW-1:0] m);
    logic [CW-1:0] w;
    w = {1'b0, m};
    return neg ? (~w + CW'(1)) : w;
  endfunction

  function automatic g2l_pkg::entry_t fit_out(input logic [CW-1:0] v);
    logic [CW+OW-1:0] e;
    e = {{OW{v[CW-1]}}, v};
    return e[OW-1:0];
  endfunction

  function automatic logic [MW-1:0] round_prod(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = p + PR_HALF;
    return s[2*F:F];
  endfunction

  // stage 1: magnitude products and the plain entries
  logic [PW-1:0] sp_cl_r, sp_sl_r, cp_cl_r, cp_sl_r;
  logic          sp_cl_neg_r, sp_sl_neg_r, cp_cl_neg_r, cp_sl_neg_r;
  logic [CW-1:0] ex_r, ey_r, nz_r, uz_r;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      sp_cl_r     <= PW'(sp_mag) * PW'(cl_mag);
      sp_sl_r     <= PW'(sp_mag) * PW'(sl_mag);
      cp_cl_r     <= PW'(cp_mag) * PW'(cl_mag);
      cp_sl_r     <= PW'(cp_mag) * PW'(sl_mag);
      sp_cl_neg_r <= sp_neg ^ cl_neg;
      sp_sl_neg_r <= sp_neg ^ sl_neg;
      cp_cl_neg_r <= cp_neg ^ cl_neg;
      cp_sl_neg_r <= cp_neg ^ sl_neg;
      ex_r        <= to_signed(!sl_neg, sl_mag);
      ey_r        <= to_signed(cl_neg, cl_mag);
      nz_r        <= to_signed(cp_neg, cp_mag);
      uz_r        <= to_signed(sp_neg, sp_mag);
    end
  end

  // stage 2: round products, apply signs, register the result word
  g2l_pkg::entry_t east_x_r, east_y_r, north_x_r, north_y_r;
  g2l_pkg::entry_t north_z_r, up_x_r, up_y_r, up_z_r;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      east_x_r  <= fit_out(ex_r);
      east_y_r  <= fit_out(ey_r);
      north_x_r <= fit_out(to_signed(!sp_cl_neg_r, round_prod(sp_cl_r)));
      north_y_r <= fit_out(to_signed(!sp_sl_neg_r, round_prod(sp_sl_r)));
      north_z_r <= fit_out(nz_r);
      up_x_r    <= fit_out(to_signed(cp_cl_neg_r, round_prod(cp_cl_r)));
      up_y_r    <= fit_out(to_signed(cp_sl_neg_r, round_prod(cp_sl_r)));
      up_z_r    <= fit_out(uz_r);
    end
  end

  assign east_x  = east_x_r;
  assign east_y  = east_y_r;
  assign north_x = north_x_r;
  assign north_y = north_y_r;
  assign north_z = north_z_r;
  assign up_x    = up_x_r;
  assign up_y    = up_y_r;
  assign up_z    = up_z_r;

endmodule

/* rtl/geodetic_to_local_rotation_matrix_top.sv */
// ECEF to east-north-up rotation matrix from a latitude/longitude pair.
//
// in_ch carries one word per position: latitude and longitude as binary
// angles (2^ANGLE_BITS per turn). out_ch carries the eight non-zero matrix
// entries, signed with COEF_FRAC_BITS fraction bits, one word per input word.
// Both channels move a word at a clock edge where valid and ready are high.
//
// Each input word passes through the stages below in order, and its result
// is offered on out_ch from the last of them. Stages: one angle split stage,
// seven stages of the sine polynomial (six with one Q30 multiply each, then
// rounding), one quadrant stage, one product stage and one rounding stage.
// Throughput is one word per cycle while out_ch.ready stays high; the
// polynomial multipliers set most of the pipeline depth.
//
// Each stage holds its own valid bit. When the receiver stalls, the words in
// flight close up behind the output register and input is still taken while
// any stage is empty; nothing is dropped or sent twice. Synchronous reset
// (rst_n low) clears all valid bits; data registers are not reset.
module geodetic_to_local_rotation_matrix_top #(
  parameter int ANGLE_BITS     = g2l_pkg::ANGLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = g2l_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  g2l_in_if.sink                  in_ch,
  g2l_out_if.source               out_ch
);

  localparam int NSC = g2l_pkg::SINCOS_STAGES;
  localparam int NM  = g2l_pkg::MUL_STAGES;
  localparam int NP  = g2l_pkg::PIPE_STAGES;

  logic [NP-1:0] load;

  logic [COEF_FRAC_BITS:0] sp_mag, cp_mag, sl_mag, cl_mag;
  logic                    sp_neg, cp_neg, sl_neg, cl_neg;

  g2l_pipe_ctrl #(
    .STAGES (NP)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .load      (load)
  );

  g2l_sincos #(
    .ANGLE_BITS     (ANGLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lat (
    .clk     (clk),
    .load    (load[NSC-1:0]),
    .angle   (in_ch.latitude_angle),
    .sin_mag (sp_mag),
    .sin_neg (sp_neg),
    .cos_mag (cp_mag),
    .cos_neg (cp_neg)
  );

  g2l_sincos #(
    .ANGLE_BITS     (ANGLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lon (
    .clk     (clk),
    .load    (load[NSC-1:0]),
    .angle   (in_ch.longitude_angle),
    .sin_mag (sl_mag),
    .sin_neg (sl_neg),
    .cos_mag (cl_mag),
    .cos_neg (cl_neg)
  );

  g2l_rot_mul #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .load    (load[NSC +: NM]),
    .sp_mag  (sp_mag),
    .sp_neg  (sp_neg),
    .cp_mag  (cp_mag),
    .cp_neg  (cp_neg),
    .sl_mag  (sl_mag),
    .sl_neg  (sl_neg),
    .cl_mag  (cl_mag),
    .cl_neg  (cl_neg),
    .east_x  (out_ch.east_x),
    .east_y  (out_ch.east_y),
    .north_x (out_ch.north_x),
    .north_y (out_ch.north_y),
    .north_z (out_ch.north_z),
    .up_x    (out_ch.up_x),
    .up_y    (out_ch.up_y),
    .up_z    (out_ch.up_z)
  );

endmodule
